>>> rtl/crc16_frame_checker_macros.svh
// Assertion macros shared by the frame checker RTL.
// No dependencies; expects clk and rst_n in the scope of each use.
`ifndef CRC16_FRAME_CHECKER_MACROS_SVH
`define CRC16_FRAME_CHECKER_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every edge outside reset
`define CRC16FC_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("crc16fc: invariant violated");

// Same-cycle implication
`define CRC16FC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("crc16fc: implication violated");

// Next-cycle implication
`define CRC16FC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("crc16fc: next-cycle implication violated");

`else

`define CRC16FC_ASSERT_ALWAYS(lbl, prop)
`define CRC16FC_ASSERT_IMPL(lbl, ante, cons)
`define CRC16FC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> rtl/crc16fc_pkg.sv
// Package for the CRC-16 frame checker: constants, result types, CRC byte step.
// No dependencies.
package crc16fc_pkg;

    // Frame format
    localparam logic [7:0]  HEAD0    = 8'hAA;
    localparam logic [7:0]  HEAD1    = 8'hBB;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef logic [12:0] len_t;

    localparam len_t BODY_MAX_LEN   = 13'd4096;
    localparam len_t BODY_LEN_RESET = 13'd260;

    typedef enum logic [1:0] {
        STATUS_OK           = 2'd0,
        STATUS_BAD_HEADER   = 2'd1,
        STATUS_CRC_MISMATCH = 2'd2
    } status_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] command;
        logic [31:0] image_size;
        logic [15:0] computed_crc;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t data;
    } result_beat_t;

    // One byte of reflected CRC-16/MODBUS, bit by bit
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> rtl/crc16fc_if.sv
// Channel interfaces of the frame checker: received bytes and check results.
// Depends on nothing; payload widths are fixed by the frame format.
interface crc16fc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface crc16fc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] command;
    logic [31:0] image_size;
    logic [15:0] computed_crc;

    modport source (output valid, output status, output command, output image_size,
                    output computed_crc, input ready);
    modport sink   (input valid, input status, input command, input image_size,
                    input computed_crc, output ready);
endinterface

>>> rtl/crc16_frame_checker.sv
// Top level of the CRC-16 frame checker: body length register, parser and result buffer.
// Depends on crc16fc_pkg, crc16fc_if.sv, crc16fc_parser and crc16fc_out_buf.
//
// Usage:
//   rx carries received bytes; frame_start on a byte marks the first header byte
//   and abandons any frame in progress. A frame is 0xAA 0xBB, body_len body bytes
//   and a two-byte check value, high byte first.
//   report carries one transfer per frame: status, command, image_size and the
//   byte-swapped CRC-16/MODBUS of the body.
//   cfg_wr_en/cfg_wr_data write body_len (values above 4096 act as 4096); write it
//   only while no frame is in progress.
// Timing:
//   One byte per cycle sustained while rx.ready is high. The result of a frame is
//   registered into the result buffer on the transfer of its last check byte; the
//   CRC step for a byte is one combinational update of the CRC register.
// Reset:
//   Clears all frame state, empties the result buffer and sets body_len to 260.
// Stalls:
//   Results queue in a two-entry buffer; rx.ready falls only when both entries
//   hold results that report has not yet taken.
module crc16_frame_checker
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  crc16fc_pkg::len_t   cfg_wr_data,
    crc16fc_in_if.sink          rx,
    crc16fc_out_if.source       report
);
    import crc16fc_pkg::*;

    len_t         body_len_reg;
    logic         buf_ready;
    logic         accept;
    result_beat_t result;

    // Body length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            body_len_reg <= BODY_LEN_RESET;
        end
        else if (cfg_wr_en)
        begin
            body_len_reg <= cfg_wr_data;
        end
    end

    assign rx.ready = buf_ready;
    assign accept   = rx.valid && buf_ready;

    crc16fc_parser u_parser
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .body_len    (body_len_reg),
        .accept      (accept),
        .rx_byte     (rx.rx_byte),
        .frame_start (rx.frame_start),
        .result      (result)
    );

    crc16fc_out_buf u_out_buf
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .result   (result),
        .in_ready (buf_ready),
        .report   (report)
    );

endmodule

>>> rtl/crc16fc_parser.sv
// Frame parser: header check, body field capture and running CRC, one byte per transfer.
// Depends on crc16fc_pkg and crc16_frame_checker_macros.svh.
`include "crc16_frame_checker_macros.svh"

module crc16fc_parser
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  crc16fc_pkg::len_t          body_len,
    input  logic                       accept,
    input  logic [7:0]                 rx_byte,
    input  logic                       frame_start,
    output crc16fc_pkg::result_beat_t  result
);
    import crc16fc_pkg::*;

    len_t        pos_reg, pos_next;
    logic [15:0] crc_reg, crc_next;
    logic        hdr_good_reg, hdr_good_next;
    logic [15:0] cmd_reg, cmd_next;
    logic [31:0] size_reg, size_next;
    logic [7:0]  chk_hi_reg, chk_hi_next;

    len_t        len;
    len_t        check_pos;
    len_t        body_idx;
    len_t        base_pos;
    logic [15:0] base_crc;
    logic        base_hdr_good;
    logic [15:0] base_cmd;
    logic [31:0] base_size;
    logic [7:0]  base_chk_hi;
    logic [15:0] swapped;
    logic [15:0] received;
    logic        last_byte;

    // Lengths beyond the buffer limit are clamped
    assign len       = (body_len > BODY_MAX_LEN) ? BODY_MAX_LEN : body_len;
    assign check_pos = len + 13'd2;

    // Frame start drops whatever frame was in progress
    always_comb
    begin
        if (frame_start)
        begin
            base_pos      = '0;
            base_crc      = CRC_INIT;
            base_hdr_good = 1'b1;
            base_cmd      = '0;
            base_size     = '0;
            base_chk_hi   = '0;
        end
        else
        begin
            base_pos      = pos_reg;
            base_crc      = crc_reg;
            base_hdr_good = hdr_good_reg;
            base_cmd      = cmd_reg;
            base_size     = size_reg;
            base_chk_hi   = chk_hi_reg;
        end
    end

    assign body_idx  = base_pos - 13'd2;
    assign swapped   = {base_crc[7:0], base_crc[15:8]};
    assign received  = {base_chk_hi, rx_byte};
    assign last_byte = (base_pos > check_pos);

    // Per-byte state update
    always_comb
    begin
        pos_next      = base_pos + 13'd1;
        crc_next      = base_crc;
        hdr_good_next = base_hdr_good;
        cmd_next      = base_cmd;
        size_next     = base_size;
        chk_hi_next   = base_chk_hi;

        if (base_pos < 13'd2)
        begin
            if (rx_byte != ((base_pos == 13'd0) ? HEAD0 : HEAD1))
            begin
                hdr_good_next = 1'b0;
            end
        end
        else if (base_pos < check_pos)
        begin
            crc_next = crc_byte(base_crc, rx_byte);
            if (body_idx < 13'd2)
            begin
                cmd_next = {base_cmd[7:0], rx_byte};
            end
            else if (body_idx < 13'd6)
            begin
                size_next = {base_size[23:0], rx_byte};
            end
        end
        else if (base_pos == check_pos)
        begin
            chk_hi_next = rx_byte;
        end
        else
        begin
            // second check byte: report and go back to waiting for a header
            pos_next      = '0;
            crc_next      = CRC_INIT;
            hdr_good_next = 1'b1;
            cmd_next      = '0;
            size_next     = '0;
            chk_hi_next   = '0;
        end
    end

    // Result of the frame, valid on the transfer of the last byte
    always_comb
    begin
        result.valid             = accept && last_byte;
        result.data.command      = base_cmd;
        result.data.image_size   = base_size;
        result.data.computed_crc = swapped;
        if (!base_hdr_good)
        begin
            result.data.status = STATUS_BAD_HEADER;
        end
        else if (swapped != received)
        begin
            result.data.status = STATUS_CRC_MISMATCH;
        end
        else
        begin
            result.data.status = STATUS_OK;
        end
    end

    // Frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            crc_reg      <= CRC_INIT;
            hdr_good_reg <= 1'b1;
            cmd_reg      <= '0;
            size_reg     <= '0;
            chk_hi_reg   <= '0;
        end
        else if (accept)
        begin
            pos_reg      <= pos_next;
            crc_reg      <= crc_next;
            hdr_good_reg <= hdr_good_next;
            cmd_reg      <= cmd_next;
            size_reg     <= size_next;
            chk_hi_reg   <= chk_hi_next;
        end
    end

    // Position never runs past the second check byte of the longest frame
    `CRC16FC_ASSERT_ALWAYS(a_pos_bound, pos_reg <= BODY_MAX_LEN + 13'd3)
    // A reported frame leaves the parser waiting for a fresh header
    `CRC16FC_ASSERT_NEXT(a_clear_after_result, result.valid, (pos_reg == 13'd0) && (crc_reg == CRC_INIT))
    // A frame start byte is always taken as the first header byte
    `CRC16FC_ASSERT_NEXT(a_restart, accept && frame_start, pos_reg == 13'd1)

endmodule

>>> rtl/crc16fc_out_buf.sv
// Two-entry result buffer: output register plus skid register on the result channel.
// Depends on crc16fc_pkg, crc16fc_if.sv and crc16_frame_checker_macros.svh.
`include "crc16_frame_checker_macros.svh"

module crc16fc_out_buf
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  crc16fc_pkg::result_beat_t  result,
    output logic                       in_ready,
    crc16fc_out_if.source              report
);
    import crc16fc_pkg::*;

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    take;

    assign take     = out_valid_reg && report.ready;
    assign in_ready = !skid_valid_reg;

    // Fill and drain of the two entries
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;

        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (result.valid)
        begin
            if (!out_valid_reg || take)
            begin
                out_data_next  = result.data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = result.data;
                skid_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign report.valid        = out_valid_reg;
    assign report.status       = out_data_reg.status;
    assign report.command      = out_data_reg.command;
    assign report.image_size   = out_data_reg.image_size;
    assign report.computed_crc = out_data_reg.computed_crc;

    // Skid entry is only ever used behind a full output entry
    `CRC16FC_ASSERT_IMPL(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    // No new result may arrive while both entries are taken
    `CRC16FC_ASSERT_IMPL(a_no_overflow, result.valid, !skid_valid_reg)
    // Draining with the skid entry full refills the output at once
    `CRC16FC_ASSERT_NEXT(a_skid_refill, take && skid_valid_reg, out_valid_reg && !skid_valid_reg)

endmodule

>>> tb/sv/tb_top.sv
// Testbench for crc16_frame_checker: sends framed bytes, predicts each frame report
// and checks every report transfer field by field.
// Depends on crc16fc_pkg, the channel interfaces in crc16fc_if.sv and the RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import crc16fc_pkg::*;

    localparam int LIMIT_CYCLES   = 600000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 64;
    localparam int NUM_PHASES     = 14;
    localparam int PRESSURE_PHASE = 3;
    localparam int RANDOM_LEN     = -1;
    localparam int DIR_ROWS       = 26;

    typedef enum int {
        FR_GOOD,
        FR_BAD_CRC,
        FR_BAD_HEADER,
        FR_TRUNCATED,
        FR_NOISE
    } frame_kind_t;

    // One row of the directed table: a body_len write or one byte
    typedef struct {
        bit         is_cfg;
        len_t       cfg_val;
        logic [7:0] data;
        bit         start;
        bit         typed;
        result_t    want;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    len_t cfg_wr_data;

    crc16fc_in_if  rx_if ();
    crc16fc_out_if rep_if ();

    crc16_frame_checker dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .rx          (rx_if),
        .report      (rep_if)
    );

    // Random phases: body_len, random byte budget, sender and receiver idle percentages
    int phase_len    [NUM_PHASES] = '{6, 1, 12, 0, 5, 33, 64, 3, 40, 260,
                                      RANDOM_LEN, RANDOM_LEN, 2, RANDOM_LEN};
    int phase_budget [NUM_PHASES] = '{110, 110, 110, 110, 110, 110, 0, 110, 0, 0,
                                      110, 110, 110, 110};
    int src_idle     [NUM_PHASES] = '{20, 30, 0, 0, 25, 15, 10, 40, 5, 20, 30, 15, 25, 0};
    int snk_idle     [NUM_PHASES] = '{20, 10, 0, 5, 25, 30, 10, 20, 5, 20, 15, 35, 25, 0};

    int      src_idle_pct    = 0;
    int      snk_idle_pct    = 0;
    bit      hold_request    = 1'b0;
    int      bytes_sent      = 0;
    int      reports_seen    = 0;
    int      n_ok            = 0;
    int      n_bad_header    = 0;
    int      n_crc_mismatch  = 0;
    int      in_stall_cycles = 0;
    int      errors          = 0;
    int      cycle_count     = 0;
    result_t expected_reports [$];

    // Parser state as the block should hold it
    len_t        cur_body_len;
    int unsigned frame_pos;
    logic [15:0] run_crc;
    bit          hdr_ok;
    logic [15:0] cmd_acc;
    logic [31:0] size_acc;
    logic [7:0]  chk_hi;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Reflected CRC-16/MODBUS, one byte
    function automatic logic [15:0] modbus_crc_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        repeat (8)
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 16'h0000);
        return c;
    endfunction

    function automatic void restart_frame();
        frame_pos = 0;
        run_crc   = CRC_INIT;
        hdr_ok    = 1'b1;
        cmd_acc   = '0;
        size_acc  = '0;
        chk_hi    = '0;
    endfunction

    // Lengths above the maximum act as the maximum
    function automatic int unsigned eff_body_len();
        return (cur_body_len > BODY_MAX_LEN) ? BODY_MAX_LEN : cur_body_len;
    endfunction

    // Advance the expected parser by one byte; 1 with the report on a frame's last byte
    function automatic bit parse_rx_byte(input logic [7:0] b, input bit start,
                                         output result_t rep);
        int unsigned len;
        int unsigned body_idx;
        logic [15:0] swapped;
        len = eff_body_len();
        rep = '0;
        if (start)
            restart_frame();
        if (frame_pos < 2)
        begin
            if (b != ((frame_pos == 0) ? HEAD0 : HEAD1))
                hdr_ok = 1'b0;
        end
        else if (frame_pos < 2 + len)
        begin
            body_idx = frame_pos - 2;
            run_crc = modbus_crc_next(run_crc, b);
            if (body_idx < 2)
                cmd_acc = {cmd_acc[7:0], b};
            else if (body_idx < 6)
                size_acc = {size_acc[23:0], b};
        end
        else if (frame_pos == 2 + len)
            chk_hi = b;
        else
        begin
            // past the last check position: the frame ends here
            swapped = {run_crc[7:0], run_crc[15:8]};
            if (!hdr_ok)
                rep.status = STATUS_BAD_HEADER;
            else if (swapped != {chk_hi, b})
                rep.status = STATUS_CRC_MISMATCH;
            else
                rep.status = STATUS_OK;
            rep.command      = cmd_acc;
            rep.image_size   = size_acc;
            rep.computed_crc = swapped;
            restart_frame();
            return 1'b1;
        end
        frame_pos = (frame_pos + 1) & 32'h1FFF;
        return 1'b0;
    endfunction

    function automatic dir_row_t byte_row(input logic [7:0] b, input bit start);
        dir_row_t r;
        r = '{is_cfg: 1'b0, cfg_val: '0, data: b, start: start, typed: 1'b0, want: '0};
        return r;
    endfunction

    function automatic dir_row_t report_row(input logic [7:0] b, input status_t st,
                                            input logic [15:0] cmd, input logic [31:0] size,
                                            input logic [15:0] crc);
        dir_row_t r;
        r = byte_row(b, 1'b0);
        r.typed = 1'b1;
        r.want  = '{status: st, command: cmd, image_size: size, computed_crc: crc};
        return r;
    endfunction

    function automatic dir_row_t cfg_row(input len_t v);
        dir_row_t r;
        r = byte_row(8'h00, 1'b0);
        r.is_cfg  = 1'b1;
        r.cfg_val = v;
        return r;
    endfunction

    // One byte transfer, with an optional idle burst in front
    task automatic send_rx_byte(input logic [7:0] b, input bit start, input bit typed,
                                input result_t want);
        int      gap;
        bit      has_rep;
        result_t rep;
        gap = 0;
        if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct)
            gap = $urandom_range(1, 8);
        if (gap != 0)
        begin
            @(negedge clk);
            rx_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        rx_if.valid       <= 1'b1;
        rx_if.rx_byte     <= b;
        rx_if.frame_start <= start;
        do
            @(posedge clk);
        while (!rx_if.ready);
        has_rep = parse_rx_byte(b, start, rep);
        if (typed)
            expected_reports.push_back(want);
        else if (has_rep)
            expected_reports.push_back(rep);
        bytes_sent++;
    endtask

    // Stop offering bytes, let every pending report drain, then let the block settle
    task automatic settle_block();
        @(negedge clk);
        rx_if.valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_body_len(input len_t v);
        settle_block();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        cur_body_len = v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // One frame of the given kind at the current body length
    task automatic send_frame(input frame_kind_t kind);
        logic [7:0]  fb [$];
        int unsigned len;
        logic [15:0] crc;
        logic [15:0] chk;
        int          n;
        bit          start;
        result_t     none;
        len  = eff_body_len();
        none = '0;
        // a frame that follows a partial one needs a restart
        start = (frame_pos != 0) || ($urandom_range(0, 1) == 1);
        if (kind == FR_NOISE)
        begin
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++)
                send_rx_byte(8'($urandom()), $urandom_range(0, 7) == 0, 1'b0, none);
            return;
        end
        fb.push_back(HEAD0);
        fb.push_back(HEAD1);
        crc = CRC_INIT;
        for (int i = 0; i < len; i++)
        begin
            logic [7:0] v;
            case ($urandom_range(0, 9))
                0:       v = 8'h00;
                1:       v = 8'hFF;
                default: v = 8'($urandom());
            endcase
            fb.push_back(v);
            crc = modbus_crc_next(crc, v);
        end
        chk = {crc[7:0], crc[15:8]};
        if (kind == FR_BAD_CRC)
            chk[$urandom_range(0, 15)] ^= 1'b1;
        fb.push_back(chk[15:8]);
        fb.push_back(chk[7:0]);
        if (kind == FR_BAD_HEADER)
        begin
            n = $urandom_range(1, 3);
            if (n[0])
                fb[0] = fb[0] ^ 8'($urandom_range(1, 255));
            if (n[1])
                fb[1] = fb[1] ^ 8'($urandom_range(1, 255));
        end
        n = fb.size();
        if (kind == FR_TRUNCATED)
            n = $urandom_range(1, fb.size() - 1);
        for (int i = 0; i < n; i++)
            send_rx_byte(fb[i], (i == 0) && start, 1'b0, none);
    endtask

    // Report receiver: random stall bursts, plus one long hold-off on request
    initial
    begin
        int stall_left;
        int hold_left;
        stall_left   = 0;
        hold_left    = 0;
        rep_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                rep_if.ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                rep_if.ready <= 1'b0;
                stall_left--;
            end
            else if (snk_idle_pct != 0 && $urandom_range(0, 99) < snk_idle_pct)
            begin
                rep_if.ready <= 1'b0;
                stall_left = $urandom_range(0, 7);
            end
            else
                rep_if.ready <= 1'b1;
        end
    end

    // Report checker
    initial
    begin
        result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && rx_if.valid && !rx_if.ready)
                in_stall_cycles++;
            if (rst_n && rep_if.valid && rep_if.ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    $error("report transfer with no frame pending: status %0d command %h",
                           rep_if.status, rep_if.command);
                    errors++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (rep_if.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rep_if.status);
                        errors++;
                    end
                    if (rep_if.command !== want.command)
                    begin
                        $error("command: expected %h, got %h", want.command, rep_if.command);
                        errors++;
                    end
                    if (rep_if.image_size !== want.image_size)
                    begin
                        $error("image_size: expected %h, got %h",
                               want.image_size, rep_if.image_size);
                        errors++;
                    end
                    if (rep_if.computed_crc !== want.computed_crc)
                    begin
                        $error("computed_crc: expected %h, got %h",
                               want.computed_crc, rep_if.computed_crc);
                        errors++;
                    end
                    reports_seen++;
                    case (rep_if.status)
                        STATUS_OK:           n_ok++;
                        STATUS_BAD_HEADER:   n_bad_header++;
                        STATUS_CRC_MISMATCH: n_crc_mismatch++;
                        default:             ;
                    endcase
                end
            end
        end
    end

    // Run limit
    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    // Stimulus
    initial
    begin
        dir_row_t    dir_table [DIR_ROWS];
        int          phase_start;
        int unsigned len_v;
        int          pick;
        frame_kind_t kind;

        rx_if.valid       = 1'b0;
        rx_if.rx_byte     = 8'h00;
        rx_if.frame_start = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_wr_data       = '0;
        rst_n             = 1'b0;
        cur_body_len      = BODY_LEN_RESET;
        restart_frame();

        // Empty bodies first, then a length change in the middle of a frame
        dir_table = '{
            cfg_row(13'd0),
            byte_row(8'hAA, 1'b1), byte_row(8'hBB, 1'b0), byte_row(8'hFF, 1'b0),
            report_row(8'hFF, STATUS_OK, 16'h0000, 32'h0000_0000, 16'hFFFF),
            byte_row(8'h00, 1'b1), byte_row(8'hBB, 1'b0), byte_row(8'hFF, 1'b0),
            report_row(8'hFF, STATUS_BAD_HEADER, 16'h0000, 32'h0000_0000, 16'hFFFF),
            // next frame follows without a start mark
            byte_row(8'hAA, 1'b0), byte_row(8'hBB, 1'b0), byte_row(8'h12, 1'b0),
            report_row(8'h34, STATUS_CRC_MISMATCH, 16'h0000, 32'h0000_0000, 16'hFFFF),
            // restart on the second byte
            byte_row(8'hAA, 1'b1), byte_row(8'hAA, 1'b1), byte_row(8'hBB, 1'b0),
            byte_row(8'hFF, 1'b0),
            report_row(8'hFF, STATUS_OK, 16'h0000, 32'h0000_0000, 16'hFFFF),
            cfg_row(13'd6),
            byte_row(8'hAA, 1'b1), byte_row(8'hBB, 1'b0), byte_row(8'h01, 1'b0),
            byte_row(8'h02, 1'b0), byte_row(8'h03, 1'b0),
            cfg_row(13'd0),
            byte_row(8'h44, 1'b0)
        };

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part
        src_idle_pct = 20;
        snk_idle_pct = 20;
        foreach (dir_table[i])
        begin
            if (dir_table[i].is_cfg)
                write_body_len(dir_table[i].cfg_val);
            else
                send_rx_byte(dir_table[i].data, dir_table[i].start, dir_table[i].typed,
                             dir_table[i].want);
        end

        // Random phases, each ending on a complete frame so the parser is clear
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            len_v = (phase_len[p] == RANDOM_LEN) ? $urandom_range(6, 48) : phase_len[p];
            write_body_len(len_t'(len_v));
            src_idle_pct = src_idle[p];
            snk_idle_pct = snk_idle[p];
            if (p == PRESSURE_PHASE)
                hold_request = 1'b1;
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < phase_budget[p])
            begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    kind = FR_GOOD;
                else if (pick < 72)
                    kind = FR_BAD_CRC;
                else if (pick < 82)
                    kind = FR_BAD_HEADER;
                else if (pick < 90)
                    kind = FR_TRUNCATED;
                else
                    kind = FR_NOISE;
                send_frame(kind);
            end
            send_frame(FR_GOOD);
        end

        settle_block();
        $display("Checked %0d frame reports from %0d bytes: %0d ok, %0d bad header,",
                 reports_seen, bytes_sent, n_ok, n_bad_header);
        $display("%0d CRC mismatch; body lengths 0 to 260; input stalled for %0d cycles.",
                 n_crc_mismatch, in_stall_cycles);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
